// ----- sv/pt64_pkg.sv -----
// Shared types, constants and the witness base table for the 64-bit primality tester.
// Used by pt64_dp, pt64_ctrl and primality_test_64; depends on nothing else.
package pt64_pkg;

    localparam logic [63:0] SMALL_LIMIT = 64'd4759123141;
    localparam int unsigned SMALL_COUNT = 3;
    localparam int unsigned LARGE_COUNT = 7;

    // Datapath operations issued by the controller.
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_SHIFT,
        OP_DBL,
        OP_NEWT_A,
        OP_NEWT_B,
        OP_NINV,
        OP_TO_ONE,
        OP_TO_MONE,
        OP_TO_MULT,
        OP_MUL_CUR,
        OP_SQR_MULT,
        OP_SQR_CUR,
        OP_SCLR,
        OP_NEXT_BASE
    } t_op;

    typedef struct packed {
        t_op  op;
        logic start;
    } t_dp_cmd;

    typedef struct packed {
        logic triv;
        logic triv_val;
        logic d_odd;
        logic dbl_last;
        logic newt_last;
        logic base_end;
        logic e_zero;
        logic e_odd;
        logic cur_one;
        logic cur_mone;
        logic s_done;
        logic mont_done;
    } t_dp_status;

    // Witness base for the given set and position; zero past the end of a set.
    function automatic logic [31:0] base_of(input logic wide_set, input logic [2:0] idx);
        logic [31:0] v;
        v = 32'd0;
        if (wide_set) begin
            case (idx)
                3'd0: v = 32'd2;
                3'd1: v = 32'd325;
                3'd2: v = 32'd9375;
                3'd3: v = 32'd28178;
                3'd4: v = 32'd450775;
                3'd5: v = 32'd9780504;
                3'd6: v = 32'd1795265022;
                default: v = 32'd0;
            endcase
        end else begin
            case (idx)
                3'd0: v = 32'd2;
                3'd1: v = 32'd7;
                3'd2: v = 32'd61;
                default: v = 32'd0;
            endcase
        end
        return v;
    endfunction

endpackage

// ----- sv/primality_test_64.sv -----
// A trivial input (0, 1, 2 or even) goes from the check state straight to the finish state.
// An odd input strips the s trailing zeros of n-1, doubles one to 2^128 mod n, runs Newton
// steps for 1/n mod 2^64, then per base converts to Montgomery form, raises to d, squares up
// to s times. A Montgomery product is three passes of the shared four-step 32x32 multiplier.
// One transaction is worked on at a time; the next is accepted once the result is loaded.
// Synchronous active-low reset empties the controller and the output register.
module primality_test_64 (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_in_valid,
    output logic         o_in_stall,
    input  logic [63:0]  i_number,
    output logic         o_out_valid,
    input  logic         i_out_stall,
    output logic         o_prime
);

    pt64_pkg::t_dp_cmd    cmd;
    pt64_pkg::t_dp_status status;

    pt64_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_prime     (o_prime),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    pt64_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .i_number (i_number),
        .o_status (status)
    );

endmodule

// ----- sv/pt64_mul.sv -----
// Multi-cycle 64x64 -> 128 unsigned multiplier built from one 32x32 multiplier.
// Stand-alone; used by pt64_mont.
module pt64_mul (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [63:0]   i_a,
    input  logic [63:0]   i_b,
    output logic          o_done,
    output logic [127:0]  o_prod
);

    logic [63:0]  r_a, r_b;
    logic [127:0] r_acc;
    logic [63:0]  r_pp;
    logic [1:0]   r_sh;
    logic [2:0]   r_cnt;
    logic         r_busy, r_done;
    logic [31:0]  a_part, b_part;

    assign a_part = r_cnt[0] ? r_a[63:32] : r_a[31:0];
    assign b_part = r_cnt[1] ? r_b[63:32] : r_b[31:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 3'd0;
        end else begin
            r_done <= r_busy && (r_cnt == 3'd4);
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 3'd0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 3'd1;
                if (r_cnt == 3'd4) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // Partial products are registered and added to the accumulator in the following cycle.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= i_a;
            r_b   <= i_b;
            r_acc <= 128'd0;
        end else if (r_busy) begin
            if (r_cnt != 3'd4) begin
                r_pp <= {32'd0, a_part} * {32'd0, b_part};
                r_sh <= {1'b0, r_cnt[0]} + {1'b0, r_cnt[1]};
            end
            if (r_cnt != 3'd0) begin
                r_acc <= r_acc + ({64'd0, r_pp} << {r_sh, 5'd0});
            end
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

    a_no_restart : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy)
        else $error("multiplier started while busy");

endmodule

// ----- sv/pt64_mont.sv -----
// Montgomery multiplier (a*b*2^-64 mod n) or plain low 64-bit product.
// Depends on pt64_mul for all three multiplications.
module pt64_mont (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic         i_low,
    input  logic [63:0]  i_a,
    input  logic [63:0]  i_b,
    input  logic [63:0]  i_n,
    input  logic [63:0]  i_ninv,
    output logic         o_done,
    output logic [63:0]  o_res
);

    typedef enum logic [4:0] {
        M_IDLE = 5'b00001,
        M_P1   = 5'b00010,
        M_P2   = 5'b00100,
        M_P3   = 5'b01000,
        M_RED  = 5'b10000
    } t_mstate;

    t_mstate      r_state, n_state;
    logic         mul_start, mul_done;
    logic [63:0]  mul_a, mul_b;
    logic [127:0] prod;
    logic [63:0]  r_hi, r_lo, r_res;
    logic [64:0]  r_sum;
    logic         r_done;

    pt64_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_prod  (prod)
    );

    always_comb begin
        n_state   = r_state;
        mul_start = 1'b0;
        mul_a     = i_a;
        mul_b     = i_b;
        case (r_state)
            M_IDLE: begin
                if (i_start) begin
                    mul_start = 1'b1;
                    n_state   = M_P1;
                end
            end
            M_P1: begin
                mul_a = prod[63:0];
                mul_b = i_ninv;
                if (mul_done) begin
                    if (i_low) begin
                        n_state = M_IDLE;
                    end else begin
                        mul_start = 1'b1;
                        n_state   = M_P2;
                    end
                end
            end
            M_P2: begin
                mul_a = prod[63:0];
                mul_b = i_n;
                if (mul_done) begin
                    mul_start = 1'b1;
                    n_state   = M_P3;
                end
            end
            M_P3: begin
                if (mul_done) begin
                    n_state = M_RED;
                end
            end
            M_RED: n_state = M_IDLE;
            default: n_state = M_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= M_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= ((r_state == M_P1) && mul_done && i_low) || (r_state == M_RED);
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == M_P1) && mul_done) begin
            r_hi <= prod[127:64];
            r_lo <= prod[63:0];
            if (i_low) begin
                r_res <= prod[63:0];
            end
        end
        // The low halves always cancel, so they carry out exactly when the low word is nonzero.
        if ((r_state == M_P3) && mul_done) begin
            r_sum <= {1'b0, r_hi} + {1'b0, prod[127:64]} + {64'd0, (r_lo != 64'd0)};
        end
        if (r_state == M_RED) begin
            r_res <= (r_sum >= {1'b0, i_n}) ? 64'(r_sum - {1'b0, i_n}) : r_sum[63:0];
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;

    a_start_idle : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> (r_state == M_IDLE))
        else $error("Montgomery unit started while busy");

endmodule

// ----- sv/pt64_dp.sv -----
// Datapath of the primality tester: operand registers, doubling, base table and
// the Montgomery unit. Depends on pt64_pkg and pt64_mont.
module pt64_dp (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  pt64_pkg::t_dp_cmd     i_cmd,
    input  logic [63:0]           i_number,
    output pt64_pkg::t_dp_status  o_status
);

    logic [63:0] r_n, r_nm1, r_d, r_e, r_r, r_inv, r_ninv, r_t;
    logic [63:0] r_one, r_mone, r_mult, r_cur;
    logic [5:0]  r_s;
    logic [6:0]  r_cnt;
    logic [2:0]  r_idx;
    logic        r_large, r_triv, r_triv_val;

    logic [63:0] nmr, dbl, base, m_a, m_b, m_res;
    logic        m_low, m_done;
    logic [2:0]  count;

    assign nmr   = r_n - r_r;
    assign dbl   = (r_r >= nmr) ? (r_r - nmr) : {r_r[62:0], 1'b0};
    assign base  = {32'd0, pt64_pkg::base_of(r_large, r_idx)};
    assign count = r_large ? 3'(pt64_pkg::LARGE_COUNT) : 3'(pt64_pkg::SMALL_COUNT);

    always_comb begin
        m_low = 1'b0;
        m_a   = r_cur;
        m_b   = r_cur;
        case (i_cmd.op)
            pt64_pkg::OP_NEWT_A: begin
                m_low = 1'b1;
                m_a   = r_n;
                m_b   = r_inv;
            end
            pt64_pkg::OP_NEWT_B: begin
                m_low = 1'b1;
                m_a   = r_inv;
                m_b   = r_t;
            end
            pt64_pkg::OP_TO_ONE: begin
                m_a = 64'd1;
                m_b = r_r;
            end
            pt64_pkg::OP_TO_MONE: begin
                m_a = r_nm1;
                m_b = r_r;
            end
            pt64_pkg::OP_TO_MULT: begin
                m_a = base;
                m_b = r_r;
            end
            pt64_pkg::OP_MUL_CUR: begin
                m_a = r_cur;
                m_b = r_mult;
            end
            pt64_pkg::OP_SQR_MULT: begin
                m_a = r_mult;
                m_b = r_mult;
            end
            default: begin
                m_a = r_cur;
                m_b = r_cur;
            end
        endcase
    end

    pt64_mont u_mont (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.start),
        .i_low   (m_low),
        .i_a     (m_a),
        .i_b     (m_b),
        .i_n     (r_n),
        .i_ninv  (r_ninv),
        .o_done  (m_done),
        .o_res   (m_res)
    );

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            pt64_pkg::OP_LOAD: begin
                r_n        <= i_number;
                r_nm1      <= i_number - 64'd1;
                r_d        <= i_number - 64'd1;
                r_s        <= 6'd0;
                r_r        <= 64'd1;
                r_inv      <= i_number;
                r_cnt      <= 7'd0;
                r_large    <= (i_number >= pt64_pkg::SMALL_LIMIT);
                r_triv     <= (i_number <= 64'd2) || !i_number[0];
                r_triv_val <= (i_number == 64'd2);
            end
            pt64_pkg::OP_SHIFT: begin
                r_d <= {1'b0, r_d[63:1]};
                r_s <= r_s + 6'd1;
            end
            // After 128 doublings of one, r holds 2^128 mod n; the counter wraps to zero.
            pt64_pkg::OP_DBL: begin
                r_r   <= dbl;
                r_cnt <= r_cnt + 7'd1;
            end
            pt64_pkg::OP_NEWT_A: begin
                if (m_done) begin
                    r_t <= 64'd2 - m_res;
                end
            end
            pt64_pkg::OP_NEWT_B: begin
                if (m_done) begin
                    r_inv <= m_res;
                    r_cnt <= r_cnt + 7'd1;
                end
            end
            pt64_pkg::OP_NINV: begin
                r_ninv <= 64'd0 - r_inv;
                r_idx  <= 3'd0;
                r_cnt  <= 7'd0;
            end
            pt64_pkg::OP_TO_ONE: begin
                if (m_done) begin
                    r_one <= m_res;
                end
            end
            pt64_pkg::OP_TO_MONE: begin
                if (m_done) begin
                    r_mone <= m_res;
                end
            end
            pt64_pkg::OP_TO_MULT: begin
                if (m_done) begin
                    r_mult <= m_res;
                    r_cur  <= r_one;
                    r_e    <= r_d;
                end
            end
            pt64_pkg::OP_MUL_CUR: begin
                if (m_done) begin
                    r_cur <= m_res;
                end
            end
            pt64_pkg::OP_SQR_MULT: begin
                if (m_done) begin
                    r_mult <= m_res;
                    r_e    <= {1'b0, r_e[63:1]};
                end
            end
            pt64_pkg::OP_SQR_CUR: begin
                if (m_done) begin
                    r_cur <= m_res;
                    r_cnt <= r_cnt + 7'd1;
                end
            end
            pt64_pkg::OP_SCLR: r_cnt <= 7'd0;
            pt64_pkg::OP_NEXT_BASE: r_idx <= r_idx + 3'd1;
            default: begin
            end
        endcase
    end

    always_comb begin
        o_status.triv      = r_triv;
        o_status.triv_val  = r_triv_val;
        o_status.d_odd     = r_d[0];
        o_status.dbl_last  = (r_cnt == 7'd127);
        o_status.newt_last = (r_cnt == 7'd4);
        o_status.base_end  = (r_idx == count) || (base >= r_n);
        o_status.e_zero    = (r_e == 64'd0);
        o_status.e_odd     = r_e[0];
        o_status.cur_one   = (r_cur == r_one);
        o_status.cur_mone  = (r_cur == r_mone);
        o_status.s_done    = (r_cnt == {1'b0, r_s});
        o_status.mont_done = m_done;
    end

endmodule

// ----- sv/pt64_ctrl.sv -----
// Controller state machine of the primality tester: sequences the datapath and
// holds the result register. Depends on pt64_pkg.
module pt64_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic                  o_prime,
    input  pt64_pkg::t_dp_status  i_status,
    output pt64_pkg::t_dp_cmd     o_cmd
);

    typedef enum logic [17:0] {
        S_IDLE     = 18'h00001,
        S_CHECK    = 18'h00002,
        S_SPLIT    = 18'h00004,
        S_DBL      = 18'h00008,
        S_NEWT_A   = 18'h00010,
        S_NEWT_B   = 18'h00020,
        S_NINV     = 18'h00040,
        S_BASE     = 18'h00080,
        S_TO_ONE   = 18'h00100,
        S_TO_MONE  = 18'h00200,
        S_TO_MULT  = 18'h00400,
        S_EXP      = 18'h00800,
        S_MUL_CUR  = 18'h01000,
        S_SQR_MULT = 18'h02000,
        S_CHK1     = 18'h04000,
        S_SLOOP    = 18'h08000,
        S_SQR_CUR  = 18'h10000,
        S_FINISH   = 18'h20000
    } t_state;

    t_state r_state, n_state;
    logic   r_issued, r_res, n_res, r_out_valid, r_prime;
    logic   mont_state, load_out, in_acc;

    assign in_acc     = i_in_valid && (r_state == S_IDLE);
    assign mont_state = (r_state == S_NEWT_A) || (r_state == S_NEWT_B) ||
                        (r_state == S_TO_ONE) || (r_state == S_TO_MONE) ||
                        (r_state == S_TO_MULT) || (r_state == S_MUL_CUR) ||
                        (r_state == S_SQR_MULT) || (r_state == S_SQR_CUR);
    assign load_out   = (r_state == S_FINISH) && (!r_out_valid || !i_out_stall);

    always_comb begin
        n_state     = r_state;
        n_res       = r_res;
        o_cmd.op    = pt64_pkg::OP_NONE;
        o_cmd.start = mont_state && !r_issued;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = pt64_pkg::OP_LOAD;
                    n_state  = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_status.triv) begin
                    n_res   = i_status.triv_val;
                    n_state = S_FINISH;
                end else begin
                    n_state = S_SPLIT;
                end
            end
            S_SPLIT: begin
                if (i_status.d_odd) begin
                    n_state = S_DBL;
                end else begin
                    o_cmd.op = pt64_pkg::OP_SHIFT;
                end
            end
            S_DBL: begin
                o_cmd.op = pt64_pkg::OP_DBL;
                if (i_status.dbl_last) begin
                    n_state = S_NEWT_A;
                end
            end
            S_NEWT_A: begin
                o_cmd.op = pt64_pkg::OP_NEWT_A;
                if (i_status.mont_done) begin
                    n_state = S_NEWT_B;
                end
            end
            S_NEWT_B: begin
                o_cmd.op = pt64_pkg::OP_NEWT_B;
                if (i_status.mont_done) begin
                    n_state = i_status.newt_last ? S_NINV : S_NEWT_A;
                end
            end
            S_NINV: begin
                o_cmd.op = pt64_pkg::OP_NINV;
                n_state  = S_BASE;
            end
            // Running out of bases, or meeting one not below n, means every round passed.
            S_BASE: begin
                if (i_status.base_end) begin
                    n_res   = 1'b1;
                    n_state = S_FINISH;
                end else begin
                    n_state = S_TO_ONE;
                end
            end
            S_TO_ONE: begin
                o_cmd.op = pt64_pkg::OP_TO_ONE;
                if (i_status.mont_done) begin
                    n_state = S_TO_MONE;
                end
            end
            S_TO_MONE: begin
                o_cmd.op = pt64_pkg::OP_TO_MONE;
                if (i_status.mont_done) begin
                    n_state = S_TO_MULT;
                end
            end
            S_TO_MULT: begin
                o_cmd.op = pt64_pkg::OP_TO_MULT;
                if (i_status.mont_done) begin
                    n_state = S_EXP;
                end
            end
            S_EXP: begin
                if (i_status.e_zero) begin
                    n_state = S_CHK1;
                end else if (i_status.e_odd) begin
                    n_state = S_MUL_CUR;
                end else begin
                    n_state = S_SQR_MULT;
                end
            end
            S_MUL_CUR: begin
                o_cmd.op = pt64_pkg::OP_MUL_CUR;
                if (i_status.mont_done) begin
                    n_state = S_SQR_MULT;
                end
            end
            S_SQR_MULT: begin
                o_cmd.op = pt64_pkg::OP_SQR_MULT;
                if (i_status.mont_done) begin
                    n_state = S_EXP;
                end
            end
            S_CHK1: begin
                if (i_status.cur_one) begin
                    o_cmd.op = pt64_pkg::OP_NEXT_BASE;
                    n_state  = S_BASE;
                end else begin
                    o_cmd.op = pt64_pkg::OP_SCLR;
                    n_state  = S_SLOOP;
                end
            end
            S_SLOOP: begin
                if (i_status.s_done) begin
                    n_res   = 1'b0;
                    n_state = S_FINISH;
                end else if (i_status.cur_mone) begin
                    o_cmd.op = pt64_pkg::OP_NEXT_BASE;
                    n_state  = S_BASE;
                end else begin
                    n_state = S_SQR_CUR;
                end
            end
            S_SQR_CUR: begin
                o_cmd.op = pt64_pkg::OP_SQR_CUR;
                if (i_status.mont_done) begin
                    n_state = S_SLOOP;
                end
            end
            S_FINISH: begin
                if (load_out) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_issued    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.start) begin
                r_issued <= 1'b1;
            end else if (i_status.mont_done) begin
                r_issued <= 1'b0;
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
        if (load_out) begin
            r_prime <= r_res;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_prime     = r_prime;

    a_accept_check : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state == S_CHECK))
        else $error("accepted transaction did not start a test");

    a_finish_out : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_out |=> r_out_valid)
        else $error("finished test produced no result");

    a_done_issued : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_status.mont_done |-> r_issued)
        else $error("Montgomery result without a pending request");

endmodule

// ----- tb/sv/primality_test_64_test.sv -----
// Testbench for primality_test_64: drives 64-bit numbers and checks each primality verdict.
// Depends on primality_test_64 and pt64_pkg; predicts verdicts with its own Miller-Rabin model.
`timescale 1ns / 100ps

module primality_test_64_test;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [63:0] i_number;
    logic        o_out_valid;
    logic        i_out_stall;
    logic        o_prime;

    int errors;
    int cycle_count;
    int send_idle_pct;
    int recv_stall_pct;

    primality_test_64 i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_number   (i_number),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_prime    (o_prime)
    );

    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH: %s", msg);
        errors++;
    endtask

    // (a * b) mod n on 128-bit intermediates.
    function automatic logic [63:0] mulmod(input logic [63:0] a, b, n);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return 64'(p % {64'd0, n});
    endfunction

    function automatic logic [63:0] powmod(input logic [63:0] a, e, n);
        logic [63:0] r;
        logic [63:0] x;
        r = 64'd1;
        x = a % n;
        while (e != 0) begin
            if (e[0]) r = mulmod(r, x, n);
            x = mulmod(x, x, n);
            e = e >> 1;
        end
        return r;
    endfunction

    function automatic logic primality_of(input logic [63:0] n);
        logic [63:0] d;
        logic [63:0] x;
        logic [31:0] a;
        logic        wide_set;
        logic        ok;
        int          s;
        int          cnt;
        if (n <= 64'd1) return 1'b0;
        if (n == 64'd2) return 1'b1;
        if (!n[0]) return 1'b0;
        d = n - 1;
        s = 0;
        while (!d[0]) begin
            d = d >> 1;
            s++;
        end
        wide_set = (n >= pt64_pkg::SMALL_LIMIT);
        cnt = wide_set ? pt64_pkg::LARGE_COUNT : pt64_pkg::SMALL_COUNT;
        for (int i = 0; i < cnt; i++) begin
            a = pt64_pkg::base_of(wide_set, 3'(i));
            if ({32'd0, a} >= n) break;
            x = powmod({32'd0, a}, d, n);
            if (x == 64'd1 || x == n - 1) continue;
            ok = 1'b0;
            for (int j = 1; j < s; j++) begin
                x = mulmod(x, x, n);
                if (x == n - 1) begin
                    ok = 1'b1;
                    break;
                end
            end
            if (!ok) return 1'b0;
        end
        return 1'b1;
    endfunction

    class verdict_board;
        logic [63:0] numbers[$];
        logic        verdicts[$];

        function void note_number(logic [63:0] n);
            numbers  = {numbers, n};
            verdicts = {verdicts, primality_of(n)};
        endfunction

        task check_verdict(logic got);
            logic [63:0] n;
            logic        want;
            if (verdicts.size() == 0) begin
                report_mismatch($sformatf("unexpected verdict %0b", got));
                return;
            end
            n = numbers.pop_front();
            want = verdicts.pop_front();
            if (got !== want)
                report_mismatch($sformatf("n=%0d verdict=%0b want %0b", n, got, want));
        endtask

        function int pending();
            return verdicts.size();
        endfunction
    endclass

    verdict_board board;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            cycle_count++;
            if (i_in_valid && !o_in_stall) board.note_number(i_number);
            if (o_out_valid && !i_out_stall) board.check_verdict(o_prime);
            if (cycle_count > 20000000) begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // Receiver stall is redrawn every falling edge according to the current phase.
    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // Valid stays high after acceptance; the next call either idles or drives a new number.
    task automatic send_number(input logic [63:0] n);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_number   <= n;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // Mostly odd numbers, many small, some near the base-set boundary and near 2^64.
    function automatic logic [63:0] random_number();
        logic [63:0] n;
        case ($urandom_range(5))
            0: n = rand64();
            1: n = 64'($urandom_range(100000));
            2: n = pt64_pkg::SMALL_LIMIT - 64'd200 + 64'($urandom_range(400));
            3: n = 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(2000));
            4: n = rand64() >> $urandom_range(63);
            default: n = {$urandom(), $urandom()} | 64'd1;
        endcase
        if ($urandom_range(9) != 0) n[0] = 1'b1;
        return n;
    endfunction

    initial begin
        logic [63:0] directed[$];
        board = new();
        errors = 0;
        cycle_count = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_number = 64'd0;
        i_out_stall = 1'b0;
        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;

        directed = '{64'd0, 64'd1, 64'd2, 64'd3, 64'd4, 64'd7, 64'd61, 64'd63, 64'd9,
                     64'd3215031751, 64'd4759123139, 64'd4759123141, 64'd4759123143,
                     64'd1795265023, 64'd3825123056546413051,
                     64'hFFFF_FFFF_FFFF_FFC5, 64'hFFFF_FFFF_FFFF_FFFF,
                     64'hFFFF_FFFF_FFFF_FFFE, 64'h8000_0000_0000_0000,
                     64'h8000_0000_0000_001D, 64'd1000000007, 64'd561,
                     64'd18446744073709551557, 64'd25326001};
        foreach (directed[k]) send_number(directed[k]);

        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct  = (ph == 1) ? 47 : (ph == 3) ? 11 : 0;
            recv_stall_pct = (ph == 2) ? 47 : (ph == 3) ? 11 : 0;
            for (int k = 0; k < 32; k++) send_number(random_number());
        end
        i_in_valid <= 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;

        while (board.pending() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule

// ----- files.f -----
sv/pt64_pkg.sv
sv/pt64_mul.sv
sv/pt64_mont.sv
sv/pt64_dp.sv
sv/pt64_ctrl.sv
sv/primality_test_64.sv
tb/sv/primality_test_64_test.sv
